FILE: design/chs_pkg.sv
// ----------------------------------------------------------------------------
// chs_pkg: shared definitions for the circular history stack
// Field widths, default sizes, command codes and sequencer states.
// ----------------------------------------------------------------------------
package chs_pkg;

    // Fixed widths of the item and register fields.
    localparam int CMD_W    = 2;
    localparam int ITEM_W   = 32;
    localparam int OFFSET_W = 6;
    localparam int CFG_W    = 7;

    // Default store size and the active depth after reset.
    localparam int               DEPTH_DEFAULT       = 64;
    localparam int               ENTRY_WIDTH_DEFAULT = 32;
    localparam logic [CFG_W-1:0] CFG_DEPTH_RESET     = 7'd64;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH  = 2'd0,
        CMD_POP   = 2'd1,
        CMD_GET   = 2'd2,
        CMD_FLUSH = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_CLEAR  = 2'd0,
        ST_REDUCE = 2'd1,
        ST_RUN    = 2'd2
    } t_state;

endpackage

FILE: design/chs_ram.sv
// ----------------------------------------------------------------------------
// chs_ram: generic single-clock RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module chs_ram #(
    parameter  int WIDTH = 32,
    parameter  int DEPTH = 64,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Read-first: a read of the entry written at the same edge sees the old data.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/chs_mod_unit.sv
// ----------------------------------------------------------------------------
// chs_mod_unit: bit-serial remainder unit
// Computes dividend mod divisor, one dividend bit per cycle (restoring).
// ----------------------------------------------------------------------------
module chs_mod_unit #(
    parameter  int PW = 6,
    parameter  int DW = 7,
    localparam int CW = $clog2(PW + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [PW-1:0] i_dividend,
    input  logic [DW-1:0] i_divisor,
    output logic          o_done,
    output logic [DW-1:0] o_remainder
);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [PW-1:0] r_src;
    logic [DW-1:0] r_rem;
    logic [DW:0]   trial;
    logic [DW:0]   step_rem;

    // The partial remainder stays below the divisor, so one compare and
    // subtract per bit is enough.
    always_comb begin
        trial    = {r_rem, r_src[PW-1]};
        step_rem = (trial >= {1'b0, i_divisor}) ? trial - {1'b0, i_divisor} : trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CW'(PW - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_src <= i_dividend;
            r_rem <= '0;
        end else if (r_busy) begin
            r_src <= r_src << 1;
            r_rem <= step_rem[DW-1:0];
        end
    end

    assign o_done      = r_done;
    assign o_remainder = r_rem;

endmodule

FILE: design/circular_history_stack_core.sv
// ----------------------------------------------------------------------------
// circular_history_stack_core: ring-buffer undo history stack
// Push, pop, get and flush over a ring of entries held in one RAM.
// ----------------------------------------------------------------------------
// Usage. Commands arrive on the input channel (i_in_valid / o_in_stall) with
// i_command, i_item_value and i_offset; every command yields exactly one item
// on the output channel (o_out_valid / i_out_stall). An item is taken at a
// rising edge where valid is high and stall is low.
// An accepted item passes through stage B and then the output register, from
// which its result is taken. Push, pop and get run back to back at one item
// per cycle while the output is not stalled: the RAM read happens in the
// accept cycle, the result and write-back in stage B, and a read that hits the
// entry being written is forwarded. A flush answers at once but then sweeps
// the RAM to zero, one entry per cycle, holding off new items while it runs.
// After reset the same sweep runs before the first item is taken.
// A write of the active depth (i_cfg_wr_en) starts a bit-serial reduction of
// the ring position modulo the new depth, during which input is stalled.
// When the receiver stalls, one result waits in the output register and one
// more command can finish into the stage behind it; after that o_in_stall is
// raised until the output register frees up.
// ----------------------------------------------------------------------------
module circular_history_stack_core #(
    parameter int DEPTH       = chs_pkg::DEPTH_DEFAULT,
    parameter int ENTRY_WIDTH = chs_pkg::ENTRY_WIDTH_DEFAULT
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // Configuration: active depth register.
    input  logic                         i_cfg_wr_en,
    input  logic [chs_pkg::CFG_W-1:0]    i_cfg_wr_data,
    // Command channel.
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [chs_pkg::CMD_W-1:0]    i_command,
    input  logic [chs_pkg::ITEM_W-1:0]   i_item_value,
    input  logic [chs_pkg::OFFSET_W-1:0] i_offset,
    // Result channel.
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [chs_pkg::ITEM_W-1:0]   o_result_value,
    output logic                         o_offset_error
);

    // Address width, depth-count width, width of position sums, and the
    // common width used to move between item and entry sizes.
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int DW   = $clog2(DEPTH + 1);
    localparam int SW   = ((DW > chs_pkg::OFFSET_W) ? DW : chs_pkg::OFFSET_W) + 1;
    localparam int XW   = (DW > chs_pkg::CFG_W) ? DW : chs_pkg::CFG_W;
    localparam int PADW = (ENTRY_WIDTH > chs_pkg::ITEM_W) ? ENTRY_WIDTH : chs_pkg::ITEM_W;

    // Effective depth: zero acts as one, anything above DEPTH acts as DEPTH.
    function automatic logic [DW-1:0] f_clamp_depth(input logic [chs_pkg::CFG_W-1:0] raw);
        logic [XW-1:0] raw_ext;
        logic [DW-1:0] depth;
        raw_ext = XW'(raw);
        if (raw_ext == '0) begin
            depth = DW'(1);
        end else if (raw_ext > XW'(DEPTH)) begin
            depth = DW'(DEPTH);
        end else begin
            depth = raw_ext[DW-1:0];
        end
        return depth;
    endfunction

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    chs_pkg::t_state r_state, n_state;
    logic [AW-1:0]   r_clr_addr, n_clr_addr;
    logic            r_need_red, n_need_red;
    logic            mod_start;
    logic            mod_done;
    logic [DW-1:0]   mod_rem;

    logic [DW-1:0]   r_depth;     // effective active depth
    logic [AW-1:0]   r_pos;       // ring position as last left by a command
    logic [AW-1:0]   r_eff;       // r_pos reduced modulo the current depth

    // Stage B: RAM read in flight, result and write-back pending.
    logic                  r_b_valid;
    chs_pkg::t_cmd         r_b_cmd;
    logic [AW-1:0]         r_b_addr;
    logic [ENTRY_WIDTH-1:0] r_b_entry;
    logic                  r_b_err;
    logic                  r_b_fwd;
    logic [ENTRY_WIDTH-1:0] r_b_fwd_data;

    // Output register.
    logic                       r_out_valid;
    logic [chs_pkg::ITEM_W-1:0] r_out_result;
    logic                       r_out_err;

    // ------------------------------------------------------------------
    // Handshake
    // ------------------------------------------------------------------
    logic out_blocked;
    logic b_done;
    logic in_accept;

    assign out_blocked = r_out_valid && i_out_stall;
    assign b_done      = r_b_valid && !out_blocked;
    assign o_in_stall  = (r_state != chs_pkg::ST_RUN) || r_need_red ||
                         (r_b_valid && out_blocked);
    assign in_accept   = i_in_valid && !o_in_stall;

    // ------------------------------------------------------------------
    // Stage A: position arithmetic and RAM address for the new command
    // ------------------------------------------------------------------
    chs_pkg::t_cmd          cmd;
    logic [SW-1:0]          eff_ext, depth_ext, off_ext, inc_pos, sum_pos;
    logic [SW-1:0]          push_pos, pop_pos, get_pos;
    logic                   get_err;
    logic [AW-1:0]          rd_addr;
    logic [AW-1:0]          new_pos;
    logic [PADW-1:0]        item_pad;
    logic [ENTRY_WIDTH-1:0] item_entry;

    always_comb begin
        cmd       = chs_pkg::t_cmd'(i_command);
        eff_ext   = SW'(r_eff);
        depth_ext = SW'(r_depth);
        off_ext   = SW'(i_offset);
        inc_pos   = eff_ext + SW'(1);
        push_pos  = (inc_pos < depth_ext) ? inc_pos : '0;
        pop_pos   = (r_eff != '0) ? eff_ext - SW'(1) : depth_ext - SW'(1);
        // Position and offset are both below the depth when the get is legal,
        // so one subtract wraps the sum.
        sum_pos   = eff_ext + off_ext;
        get_pos   = (sum_pos >= depth_ext) ? sum_pos - depth_ext : sum_pos;
        get_err   = (off_ext >= depth_ext);
        item_pad  = PADW'(i_item_value);
        item_entry = item_pad[ENTRY_WIDTH-1:0];

        case (cmd)
            chs_pkg::CMD_PUSH: begin
                rd_addr = r_eff;
                new_pos = push_pos[AW-1:0];
            end
            chs_pkg::CMD_POP: begin
                rd_addr = pop_pos[AW-1:0];
                new_pos = pop_pos[AW-1:0];
            end
            chs_pkg::CMD_GET: begin
                rd_addr = get_pos[AW-1:0];
                new_pos = r_eff;
            end
            default: begin
                rd_addr = r_eff;
                new_pos = r_eff;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Stage B: result selection and write-back
    // ------------------------------------------------------------------
    logic                   b_we;
    logic [ENTRY_WIDTH-1:0] b_wdata;
    logic [ENTRY_WIDTH-1:0] ram_rdata;
    logic [ENTRY_WIDTH-1:0] b_data;
    logic [PADW-1:0]        b_data_pad;
    logic [chs_pkg::ITEM_W-1:0] b_result;
    logic                   fwd_hit;

    always_comb begin
        b_we    = 1'b0;
        b_wdata = '0;
        case (r_b_cmd)
            chs_pkg::CMD_PUSH: begin
                b_we    = 1'b1;
                b_wdata = r_b_entry;
            end
            chs_pkg::CMD_POP: begin
                b_we    = 1'b1;
            end
            default: begin
                b_we    = 1'b0;
            end
        endcase

        // A read issued at the edge where stage B writes the same entry
        // returns stale data, so the written value is carried along instead.
        b_data     = r_b_fwd ? r_b_fwd_data : ram_rdata;
        b_data_pad = PADW'(b_data);

        case (r_b_cmd)
            chs_pkg::CMD_PUSH,
            chs_pkg::CMD_POP: begin
                b_result = b_data_pad[chs_pkg::ITEM_W-1:0];
            end
            chs_pkg::CMD_GET: begin
                b_result = r_b_err ? '0 : b_data_pad[chs_pkg::ITEM_W-1:0];
            end
            default: begin
                b_result = '0;
            end
        endcase

        fwd_hit = b_done && b_we && (r_b_addr == rd_addr);
    end

    // ------------------------------------------------------------------
    // RAM ports: the clearing sweep owns the write port while it runs.
    // ------------------------------------------------------------------
    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [ENTRY_WIDTH-1:0] ram_wdata;

    always_comb begin
        if (r_state == chs_pkg::ST_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_addr;
            ram_wdata = '0;
        end else begin
            ram_we    = b_done && b_we;
            ram_waddr = r_b_addr;
            ram_wdata = b_wdata;
        end
    end

    chs_ram #(
        .WIDTH (ENTRY_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (in_accept),
        .i_raddr (rd_addr),
        .o_rdata (ram_rdata)
    );

    chs_mod_unit #(
        .PW (AW),
        .DW (DW)
    ) u_mod (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (mod_start),
        .i_dividend  (r_pos),
        .i_divisor   (r_depth),
        .o_done      (mod_done),
        .o_remainder (mod_rem)
    );

    // ------------------------------------------------------------------
    // Sequencer: reset/flush clearing sweep, position reduction, run.
    // ------------------------------------------------------------------
    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        mod_start  = 1'b0;

        case (r_state)
            chs_pkg::ST_CLEAR: begin
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == AW'(DEPTH - 1)) begin
                    n_clr_addr = '0;
                    n_state    = chs_pkg::ST_RUN;
                end
            end
            chs_pkg::ST_REDUCE: begin
                // A depth write during the reduction restarts it.
                if (r_need_red) begin
                    mod_start = 1'b1;
                end else if (mod_done) begin
                    n_state = chs_pkg::ST_RUN;
                end
            end
            chs_pkg::ST_RUN: begin
                if (r_need_red) begin
                    mod_start = 1'b1;
                    n_state   = chs_pkg::ST_REDUCE;
                end else if (in_accept && (cmd == chs_pkg::CMD_FLUSH)) begin
                    n_state = chs_pkg::ST_CLEAR;
                end
            end
            default: begin
                n_state = chs_pkg::ST_RUN;
            end
        endcase

        if (i_cfg_wr_en) begin
            n_need_red = 1'b1;
        end else if (mod_start) begin
            n_need_red = 1'b0;
        end else begin
            n_need_red = r_need_red;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= chs_pkg::ST_CLEAR;
            r_clr_addr <= '0;
            r_need_red <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_need_red <= n_need_red;
        end
    end

    // Active depth and ring position.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth <= f_clamp_depth(chs_pkg::CFG_DEPTH_RESET);
            r_pos   <= '0;
            r_eff   <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_depth <= f_clamp_depth(i_cfg_wr_data);
            end
            if (in_accept) begin
                r_pos <= new_pos;
                r_eff <= new_pos;
            end else if ((r_state == chs_pkg::ST_REDUCE) && mod_done && !r_need_red) begin
                r_eff <= mod_rem[AW-1:0];
            end
        end
    end

    // Stage B and output register control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_b_valid <= 1'b1;
            end else if (b_done) begin
                r_b_valid <= 1'b0;
            end
            if (b_done) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Stage B and output payload.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_b_cmd      <= cmd;
            r_b_addr     <= rd_addr;
            r_b_entry    <= item_entry;
            r_b_err      <= (cmd == chs_pkg::CMD_GET) && get_err;
            r_b_fwd      <= fwd_hit;
            r_b_fwd_data <= b_wdata;
        end
        if (b_done) begin
            r_out_result <= b_result;
            r_out_err    <= r_b_err;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_result_value = r_out_result;
    assign o_offset_error = r_out_err;

endmodule

FILE: tb/chs_history_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// chs_history_checker: result predictor and comparator for the history stack
// Keeps its own copy of the ring, the position and the active depth, works out
// the answer to every accepted command and compares it with the block's results.
// ----------------------------------------------------------------------------
module chs_history_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic [chs_pkg::CFG_W-1:0]    i_cfg_wr_data,
    input  logic                         i_in_valid,
    input  logic                         i_in_stall,
    input  logic [chs_pkg::CMD_W-1:0]    i_command,
    input  logic [chs_pkg::ITEM_W-1:0]   i_item_value,
    input  logic [chs_pkg::OFFSET_W-1:0] i_offset,
    input  logic                         i_out_valid,
    input  logic                         i_out_stall,
    input  logic [chs_pkg::ITEM_W-1:0]   i_result_value,
    input  logic                         i_offset_error,
    output int                           o_fail_count,
    output int                           o_pending
);

    localparam int RING_SIZE = chs_pkg::DEPTH_DEFAULT;

    typedef struct {
        chs_pkg::t_cmd              cmd;
        logic [chs_pkg::ITEM_W-1:0] value;
        logic                       offset_error;
    } t_stack_answer;

    logic [chs_pkg::ITEM_W-1:0] ring_copy [RING_SIZE];
    int unsigned                ring_pos;
    logic [chs_pkg::CFG_W-1:0]  depth_copy;
    t_stack_answer              answers_due [$];
    int                         fails = 0;

    task automatic report_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        fails++;
    endtask

    // Depth settings outside 1..RING_SIZE are clamped into that range.
    function automatic int unsigned live_depth();
        if (depth_copy == 0) return 1;
        if (depth_copy > RING_SIZE) return RING_SIZE;
        return depth_copy;
    endfunction

    function automatic t_stack_answer predict_stack_op(
        input chs_pkg::t_cmd                cmd,
        input logic [chs_pkg::ITEM_W-1:0]   value,
        input logic [chs_pkg::OFFSET_W-1:0] ofs);
        t_stack_answer ans;
        int unsigned   d;
        int unsigned   pos;
        d   = live_depth();
        // A position left beyond a lowered depth is folded back first.
        pos = ring_pos % d;
        ans.cmd          = cmd;
        ans.value        = '0;
        ans.offset_error = 1'b0;
        case (cmd)
            chs_pkg::CMD_PUSH: begin
                ans.value      = ring_copy[pos];
                ring_copy[pos] = value;
                pos            = (pos + 1 < d) ? pos + 1 : 0;
            end
            chs_pkg::CMD_POP: begin
                pos            = (pos > 0) ? pos - 1 : d - 1;
                ans.value      = ring_copy[pos];
                ring_copy[pos] = '0;
            end
            chs_pkg::CMD_GET: begin
                if (ofs >= d) begin
                    ans.offset_error = 1'b1;
                end else begin
                    ans.value = ring_copy[(pos + ofs) % d];
                end
            end
            default: begin
                foreach (ring_copy[k]) ring_copy[k] = '0;
            end
        endcase
        ring_pos = pos;
        return ans;
    endfunction

    always @(posedge i_clk) begin : watch_channels
        t_stack_answer due;
        if (!i_rst_n) begin
            foreach (ring_copy[k]) ring_copy[k] = '0;
            ring_pos   = 0;
            depth_copy = chs_pkg::CFG_DEPTH_RESET;
            answers_due.delete();
        end else begin
            // Results leave only after stage B and the output register, so the output
            // side is settled before this edge's command is predicted.
            if (i_out_valid === 1'b1 && i_out_stall === 1'b0) begin
                if (answers_due.size() == 0) begin
                    report_mismatch("result item with no command outstanding");
                end else begin
                    due = answers_due.pop_front();
                    if (i_result_value !== due.value)
                        report_mismatch($sformatf("%s result_value got %h want %h",
                                                  due.cmd.name(), i_result_value, due.value));
                    if (i_offset_error !== due.offset_error)
                        report_mismatch($sformatf("%s offset_error got %b want %b",
                                                  due.cmd.name(), i_offset_error,
                                                  due.offset_error));
                end
            end
            if (i_cfg_wr_en === 1'b1) depth_copy = i_cfg_wr_data;
            if (i_in_valid === 1'b1 && i_in_stall === 1'b0)
                answers_due.push_back(predict_stack_op(chs_pkg::t_cmd'(i_command),
                                                       i_item_value, i_offset));
        end
        o_pending    <= answers_due.size();
        o_fail_count <= fails;
    end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: regression bench for circular_history_stack_core
// Drives push, pop, get and flush commands over a series of active depths with
// random idling on both channels, and lets a side checker predict and compare
// every result item.
// ----------------------------------------------------------------------------
module tb;

    // The limit leaves ample margin over the slowest correct run.
    localparam int CYCLE_LIMIT = 800_000;
    // Length of the deliberate receiver hold-off that backs up the block.
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_COUNT = 14;
    localparam int PHASE_ITEMS = 75;

    logic                         i_clk         = 1'b0;
    logic                         i_rst_n       = 1'b0;
    logic                         i_cfg_wr_en   = 1'b0;
    logic [chs_pkg::CFG_W-1:0]    i_cfg_wr_data = '0;
    logic                         i_in_valid    = 1'b0;
    logic                         o_in_stall;
    logic [chs_pkg::CMD_W-1:0]    i_command     = chs_pkg::CMD_PUSH;
    logic [chs_pkg::ITEM_W-1:0]   i_item_value  = '0;
    logic [chs_pkg::OFFSET_W-1:0] i_offset      = '0;
    logic                         o_out_valid;
    logic                         i_out_stall   = 1'b0;
    logic [chs_pkg::ITEM_W-1:0]   o_result_value;
    logic                         o_offset_error;

    int                        fail_count;
    int                        pending;
    int                        cycle_count = 0;
    logic [chs_pkg::CFG_W-1:0] depth_setting = chs_pkg::CFG_DEPTH_RESET;
    // When set, neither side idles: back-to-back items at full rate.
    bit                        no_idle = 1'b0;
    // Request from the stimulus side for one long receiver hold-off.
    bit                        hold_req = 1'b0;

    circular_history_stack_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_command      (i_command),
        .i_item_value   (i_item_value),
        .i_offset       (i_offset),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_result_value (o_result_value),
        .o_offset_error (o_offset_error)
    );

    chs_history_checker checker_i (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_command      (i_command),
        .i_item_value   (i_item_value),
        .i_offset       (i_offset),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_result_value (o_result_value),
        .i_offset_error (o_offset_error),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Watchdog: a run that has not reached its verdict by the limit has hung.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Regression FAIL");
        $finish;
    end

    // Idle length for either side. Most gaps are short, a few are long, and
    // pct sets how often a gap is taken at all.
    function automatic int idle_gap(input int pct);
        if (no_idle || $urandom_range(0, 99) >= pct) return 0;
        if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // The depth the block really uses for the current register value.
    function automatic int live_depth();
        if (depth_setting == 0) return 1;
        if (depth_setting > chs_pkg::DEPTH_DEFAULT) return chs_pkg::DEPTH_DEFAULT;
        return depth_setting;
    endfunction

    // Receiver. Stall is decided once per edge from its own countdown, so it
    // never depends on the order of processes within a step. A hold-off
    // request replaces any short stall with one long stretch.
    initial begin : receiver
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req   = 1'b0;
                stall_left = HOLD_CYCLES;
            end else if (stall_left == 0) begin
                stall_left = idle_gap(20);
            end
            if (stall_left > 0) begin
                i_out_stall <= 1'b1;
                stall_left--;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // Offers one command item and holds it until the block takes it. Valid
    // stays high into the next item when no gap follows, so it is never
    // dropped and raised again in the same step.
    task automatic send_command(input chs_pkg::t_cmd cmd,
                                input logic [chs_pkg::ITEM_W-1:0] value,
                                input logic [chs_pkg::OFFSET_W-1:0] ofs);
        int gap;
        i_in_valid   <= 1'b1;
        i_command    <= cmd;
        i_item_value <= value;
        i_offset     <= ofs;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        gap = idle_gap(40);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Waits until every result has come back and the block no longer holds
    // off input, which also covers the clearing sweep after reset or a flush.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0 || o_in_stall !== 1'b0);
    endtask

    // Writes the active depth while the block is idle.
    task automatic write_depth(input logic [chs_pkg::CFG_W-1:0] value);
        wait_idle();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        depth_setting = value;
    endtask

    // Random traffic: mostly pushes, pops and gets that exercise the ring as
    // an undo history, with an occasional flush. Gets mostly aim inside the
    // active depth, the rest land anywhere so out-of-range offsets appear.
    task automatic run_phase(input int count);
        chs_pkg::t_cmd                cmd;
        logic [chs_pkg::ITEM_W-1:0]   value;
        logic [chs_pkg::OFFSET_W-1:0] ofs;
        int                           pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 40)      cmd = chs_pkg::CMD_PUSH;
            else if (pick < 65) cmd = chs_pkg::CMD_POP;
            else if (pick < 97) cmd = chs_pkg::CMD_GET;
            else                cmd = chs_pkg::CMD_FLUSH;
            pick = $urandom_range(0, 19);
            if (pick == 0)      value = '0;
            else if (pick == 1) value = '1;
            else                value = $urandom();
            if ($urandom_range(0, 3) != 0) pick = $urandom_range(0, live_depth() - 1);
            else                           pick = $urandom_range(0, 63);
            ofs = pick[chs_pkg::OFFSET_W-1:0];
            send_command(cmd, value, ofs);
        end
    endtask

    // Depth for each random phase: a fixed list with the extremes, the out-of-range
    // settings on both sides and some values between, then the rest at random over the whole field.
    function automatic logic [chs_pkg::CFG_W-1:0] phase_depth(input int phase);
        int pick;
        pick = $urandom_range(0, 127);
        case (phase)
            0:       return 7'd1;
            1:       return 7'd0;
            2:       return 7'd127;
            3:       return 7'd65;
            4:       return 7'd2;
            5:       return 7'd64;
            6:       return 7'd3;
            7:       return 7'd17;
            8:       return 7'd8;
            9:       return 7'd33;
            default: return pick[chs_pkg::CFG_W-1:0];
        endcase
    endfunction

    initial begin : stimulus
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Full depth first, position at zero.
        write_depth(chs_pkg::CFG_DEPTH_RESET);

        // Popping an empty history still steps back and wraps to the top.
        send_command(chs_pkg::CMD_POP, '0, '0);
        send_command(chs_pkg::CMD_PUSH, 32'hFFFF_FFFF, '0);
        send_command(chs_pkg::CMD_PUSH, 32'h0000_0000, '0);
        send_command(chs_pkg::CMD_PUSH, 32'hA5A5_A5A5, '0);
        send_command(chs_pkg::CMD_PUSH, 32'h5A5A_5A5A, '0);
        // Reads at the smallest and largest offsets, the latter wrapping.
        send_command(chs_pkg::CMD_GET, '0, 6'd0);
        send_command(chs_pkg::CMD_GET, '0, 6'd63);
        send_command(chs_pkg::CMD_GET, '0, 6'd60);
        send_command(chs_pkg::CMD_POP, '0, '0);
        send_command(chs_pkg::CMD_POP, '0, '0);
        // Flush empties everything but keeps the position.
        send_command(chs_pkg::CMD_FLUSH, 32'hFFFF_FFFF, 6'd63);
        send_command(chs_pkg::CMD_GET, '0, 6'd63);
        for (int n = 0; n < 4; n++) send_command(chs_pkg::CMD_PUSH, $urandom(), '0);

        // Lowering the depth below the current position folds it back in.
        write_depth(7'd3);
        for (int n = 0; n < 4; n++) send_command(chs_pkg::CMD_PUSH, $urandom(), '0);
        send_command(chs_pkg::CMD_GET, '0, 6'd2);
        // Offsets at and far beyond the depth flag an error and read nothing.
        send_command(chs_pkg::CMD_GET, '0, 6'd3);
        send_command(chs_pkg::CMD_GET, '0, 6'd63);
        send_command(chs_pkg::CMD_POP, '0, '0);

        for (int p = 0; p < PHASE_COUNT; p++) begin
            write_depth(phase_depth(p));
            no_idle = (p % 4 == 3);
            // Back the block up: the receiver holds off while items keep coming.
            if (p == 2 || p == 9) hold_req = 1'b1;
            run_phase(PHASE_ITEMS);
        end
        no_idle = 1'b0;

        wait_idle();
        // Room for a trailing flush sweep and any stray result.
        repeat (chs_pkg::DEPTH_DEFAULT + 16) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
